// ===== hdl/dgst_pkg.sv =====
// shared types and constants for the session sequence tracker
package dgst_pkg;

  localparam logic [7:0]  MSG_CONNECT    = 8'd3;
  localparam logic [7:0]  MSG_PING       = 8'd1;
  localparam logic [31:0] ACT_CONNECT    = 32'd0;
  localparam logic [19:0] IDLE_LIMIT_RST = 20'd30000;
  localparam logic [4:0]  REMOVED_MAX    = 5'd31;
  localparam logic [31:0] IDLE_SAT       = 32'hFFFF_FFFF;

  typedef enum logic [3:0] {
    ST_NEW_ACK    = 4'd0,
    ST_REPEAT_ACK = 4'd1,
    ST_PING       = 4'd2,
    ST_DUP_REACK  = 4'd3,
    ST_GAP_DROP   = 4'd4,
    ST_FWD_ACK    = 4'd5,
    ST_UNKNOWN    = 4'd6,
    ST_TABLE_FULL = 4'd7,
    ST_TICK_DONE  = 4'd8
  } status_t;

  // one session entry as kept in the table memory
  typedef struct packed {
    logic [31:0]        addr;
    logic [15:0]        port;
    logic [31:0]        player;
    logic signed [31:0] last_req;
    logic [31:0]        idle;
  } ent_t;

  localparam int ENT_W = $bits(ent_t);

  // flags from the shared compare/add unit
  typedef struct packed {
    logic        hit;
    logic        stale;
    logic        in_order;
    logic        expire;
    logic [31:0] idle_new;
  } alu_res_t;

endpackage

// ===== hdl/dgst_ram.sv =====
// generic simple dual-port ram with registered read
module dgst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/dgst_alu.sv =====
// shared compare and saturating add unit used by the scan steps and the decide step
module dgst_alu (
  input  dgst_pkg::ent_t      ent,
  input  logic [31:0]         addr,
  input  logic [15:0]         port,
  input  logic signed [31:0]  req,
  input  logic [15:0]         delay,
  input  logic [19:0]         limit,
  output dgst_pkg::alu_res_t  res
);
  import dgst_pkg::*;

  logic [32:0]        sum;
  logic signed [31:0] last_inc;

  always_comb begin
    sum          = {1'b0, ent.idle} + {17'b0, delay};
    // wrap of last+1 only matters when last is the max value, which is stale anyway
    last_inc     = ent.last_req + 32'sd1;
    res.hit      = (ent.addr == addr) && (ent.port == port);
    res.stale    = ($signed(ent.last_req) >= req);
    res.in_order = (last_inc == req);
    res.idle_new = sum[32] ? IDLE_SAT : sum[31:0];
    res.expire   = (res.idle_new >= {12'b0, limit});
  end

endmodule

// ===== hdl/datagram_session_sequence_tracker_core.sv =====
// top level: session table sequencer with table memory and shared compare unit
// a datagram scans every slot of the table memory, then decides in S_DEXEC and strobes
//   out_valid; a tick strobes at the end of its scan; one slot is read per cycle
// busy is high from start until the result strobe, and no new request is taken meanwhile
// the result strobe lasts one cycle and cannot be stalled
// reset (rst_n low, synchronous) empties the table, clears the player counter and
//   sets idle_limit to 30000; no clearing pass is needed
module datagram_session_sequence_tracker_core #(
  parameter int MAX_SESSIONS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic                in_kind,
  input  logic [7:0]          in_msg_type,
  input  logic signed [31:0]  in_req_id,
  input  logic [31:0]         in_action_code,
  input  logic [31:0]         in_entity_id,
  input  logic [63:0]         in_args_high,
  input  logic [63:0]         in_args_low,
  input  logic [31:0]         in_src_addr,
  input  logic [15:0]         in_src_port,
  input  logic [15:0]         in_tick_delay,
  output logic                out_valid,
  output logic [3:0]          out_status,
  output logic signed [31:0]  out_ack_req_id,
  output logic [31:0]         out_ack_value,
  output logic [31:0]         out_dest_addr,
  output logic [15:0]         out_dest_port,
  output logic [31:0]         out_player_id,
  output logic [31:0]         out_fwd_action,
  output logic [31:0]         out_fwd_entity,
  output logic [63:0]         out_fwd_args_high,
  output logic [63:0]         out_fwd_args_low,
  output logic [4:0]          out_removed_count,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [19:0]         cfg_idle_limit
);
  import dgst_pkg::*;

  localparam int IDX_W = (MAX_SESSIONS > 1) ? $clog2(MAX_SESSIONS) : 1;
  localparam int CNT_W = $clog2(MAX_SESSIONS + 1);
  localparam logic [CNT_W-1:0] CNT_END = CNT_W'(MAX_SESSIONS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DSCAN,
    S_DEXEC,
    S_TSCAN
  } state_t;

  state_t                  state_r;
  logic [MAX_SESSIONS-1:0] valid_r;
  logic [19:0]             limit_r;
  logic [31:0]             next_player_r;
  logic [CNT_W-1:0]        cnt_r;
  logic                    pend_r;
  logic [IDX_W-1:0]        pend_idx_r;
  logic                    hit_r;
  logic [IDX_W-1:0]        hit_idx_r;
  ent_t                    ent_r;
  logic                    free_found_r;
  logic [IDX_W-1:0]        free_idx_r;
  logic [4:0]              removed_r;
  logic [4:0]              removed_nxt;

  // latched request
  logic [7:0]         mtype_r;
  logic signed [31:0] req_r;
  logic [31:0]        action_r;
  logic [31:0]        entity_r;
  logic [63:0]        args_high_r;
  logic [63:0]        args_low_r;
  logic [31:0]        addr_r;
  logic [15:0]        port_r;
  logic [15:0]        delay_r;

  // registered result
  logic               out_valid_r;
  status_t            status_r;
  logic signed [31:0] ack_req_r;
  logic [31:0]        ack_value_r;
  logic [31:0]        dest_addr_r;
  logic [15:0]        dest_port_r;
  logic [31:0]        player_r;
  logic [31:0]        fwd_action_r;
  logic [31:0]        fwd_entity_r;
  logic [63:0]        fwd_args_high_r;
  logic [63:0]        fwd_args_low_r;
  logic [4:0]         removed_out_r;

  logic [IDX_W-1:0] cnt_idx;
  logic             issue;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  ent_t             ram_wdata;
  logic [ENT_W-1:0] ram_rdata;
  ent_t             rd_ent;
  ent_t             alu_ent;
  alu_res_t         alu;
  logic             is_connect;
  logic             is_ping;
  logic [31:0]      np;

  assign cnt_idx    = cnt_r[IDX_W-1:0];
  assign issue      = (cnt_r != CNT_END);
  assign rd_ent     = ent_t'(ram_rdata);
  assign alu_ent    = (state_r == S_DEXEC) ? ent_r : rd_ent;
  assign is_connect = (mtype_r == MSG_CONNECT) && (action_r == ACT_CONNECT);
  assign is_ping    = (mtype_r == MSG_PING);
  assign np         = next_player_r + 32'd1;

  dgst_ram #(
    .WIDTH(ENT_W),
    .DEPTH(MAX_SESSIONS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(cnt_idx),
    .rdata(ram_rdata)
  );

  dgst_alu u_alu (
    .ent  (alu_ent),
    .addr (addr_r),
    .port (port_r),
    .req  (req_r),
    .delay(delay_r),
    .limit(limit_r),
    .res  (alu)
  );

  always_comb begin
    removed_nxt = removed_r;
    if (state_r == S_TSCAN && pend_r && valid_r[pend_idx_r] && alu.expire &&
        removed_r != REMOVED_MAX) begin
      removed_nxt = removed_r + 5'd1;
    end
  end

  // table write port
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pend_idx_r;
    ram_wdata = rd_ent;
    case (state_r)
      S_TSCAN: begin
        if (pend_r && valid_r[pend_idx_r]) begin
          ram_we         = 1'b1;
          ram_wdata.idle = alu.idle_new;
        end
      end
      S_DEXEC: begin
        ram_waddr = hit_idx_r;
        ram_wdata = ent_r;
        if (is_connect) begin
          if (hit_r) begin
            ram_we             = 1'b1;
            ram_wdata.last_req = req_r;
          end else if (free_found_r) begin
            ram_we             = 1'b1;
            ram_waddr          = free_idx_r;
            ram_wdata.addr     = addr_r;
            ram_wdata.port     = port_r;
            ram_wdata.player   = np;
            ram_wdata.last_req = req_r;
            ram_wdata.idle     = 32'd0;
          end
        end else if (hit_r) begin
          ram_we         = 1'b1;
          ram_wdata.idle = 32'd0;
          if (!is_ping && !alu.stale && alu.in_order) begin
            ram_wdata.last_req = req_r;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      valid_r       <= '0;
      limit_r       <= IDLE_LIMIT_RST;
      next_player_r <= 32'd0;
      cnt_r         <= '0;
      pend_r        <= 1'b0;
      hit_r         <= 1'b0;
      free_found_r  <= 1'b0;
      removed_r     <= 5'd0;
      out_valid_r   <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_idle_limit;
      end
      case (state_r)
        S_IDLE: begin
          if (start) begin
            mtype_r      <= in_msg_type;
            req_r        <= in_req_id;
            action_r     <= in_action_code;
            entity_r     <= in_entity_id;
            args_high_r  <= in_args_high;
            args_low_r   <= in_args_low;
            addr_r       <= in_src_addr;
            port_r       <= in_src_port;
            delay_r      <= in_tick_delay;
            cnt_r        <= '0;
            pend_r       <= 1'b0;
            hit_r        <= 1'b0;
            free_found_r <= 1'b0;
            removed_r    <= 5'd0;
            state_r      <= in_kind ? S_TSCAN : S_DSCAN;
          end
        end
        S_DSCAN: begin
          pend_r     <= issue;
          pend_idx_r <= cnt_idx;
          if (issue) begin
            cnt_r <= cnt_r + 1'b1;
            // lowest free slot, in case this is a new client
            if (!free_found_r && !valid_r[cnt_idx]) begin
              free_found_r <= 1'b1;
              free_idx_r   <= cnt_idx;
            end
          end
          if (pend_r && valid_r[pend_idx_r] && alu.hit && !hit_r) begin
            hit_r     <= 1'b1;
            hit_idx_r <= pend_idx_r;
            ent_r     <= rd_ent;
          end
          if (!issue) begin
            state_r <= S_DEXEC;
          end
        end
        S_DEXEC: begin
          out_valid_r     <= 1'b1;
          ack_req_r       <= 32'sd0;
          ack_value_r     <= 32'd0;
          dest_addr_r     <= 32'd0;
          dest_port_r     <= 16'd0;
          player_r        <= 32'd0;
          fwd_action_r    <= 32'd0;
          fwd_entity_r    <= 32'd0;
          fwd_args_high_r <= 64'd0;
          fwd_args_low_r  <= 64'd0;
          removed_out_r   <= 5'd0;
          if (is_connect) begin
            if (hit_r || free_found_r) begin
              ack_req_r   <= req_r;
              dest_addr_r <= addr_r;
              dest_port_r <= port_r;
            end
            if (hit_r) begin
              status_r    <= ST_REPEAT_ACK;
              ack_value_r <= ent_r.player;
              player_r    <= ent_r.player;
            end else if (free_found_r) begin
              status_r              <= ST_NEW_ACK;
              ack_value_r           <= np;
              player_r              <= np;
              next_player_r         <= np;
              valid_r[free_idx_r]   <= 1'b1;
            end else begin
              status_r <= ST_TABLE_FULL;
            end
          end else if (!hit_r) begin
            status_r <= ST_UNKNOWN;
          end else begin
            player_r <= ent_r.player;
            if (is_ping) begin
              status_r <= ST_PING;
            end else if (alu.stale) begin
              status_r    <= ST_DUP_REACK;
              ack_req_r   <= req_r;
              dest_addr_r <= addr_r;
              dest_port_r <= port_r;
            end else if (!alu.in_order) begin
              status_r <= ST_GAP_DROP;
            end else begin
              status_r        <= ST_FWD_ACK;
              ack_req_r       <= req_r;
              ack_value_r     <= ent_r.player;
              dest_addr_r     <= addr_r;
              dest_port_r     <= port_r;
              fwd_action_r    <= action_r;
              fwd_entity_r    <= entity_r;
              fwd_args_high_r <= args_high_r;
              fwd_args_low_r  <= args_low_r;
            end
          end
          state_r <= S_IDLE;
        end
        S_TSCAN: begin
          pend_r     <= issue;
          pend_idx_r <= cnt_idx;
          removed_r  <= removed_nxt;
          if (issue) begin
            cnt_r <= cnt_r + 1'b1;
          end
          if (pend_r && valid_r[pend_idx_r] && alu.expire) begin
            valid_r[pend_idx_r] <= 1'b0;
          end
          if (!issue) begin
            out_valid_r     <= 1'b1;
            status_r        <= ST_TICK_DONE;
            ack_req_r       <= 32'sd0;
            ack_value_r     <= 32'd0;
            dest_addr_r     <= 32'd0;
            dest_port_r     <= 16'd0;
            player_r        <= 32'd0;
            fwd_action_r    <= 32'd0;
            fwd_entity_r    <= 32'd0;
            fwd_args_high_r <= 64'd0;
            fwd_args_low_r  <= 64'd0;
            removed_out_r   <= removed_nxt;
            state_r         <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy              = (state_r != S_IDLE);
  assign cfg_ready         = (state_r == S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_ack_req_id    = ack_req_r;
  assign out_ack_value     = ack_value_r;
  assign out_dest_addr     = dest_addr_r;
  assign out_dest_port     = dest_port_r;
  assign out_player_id     = player_r;
  assign out_fwd_action    = fwd_action_r;
  assign out_fwd_entity    = fwd_entity_r;
  assign out_fwd_args_high = fwd_args_high_r;
  assign out_fwd_args_low  = fwd_args_low_r;
  assign out_removed_count = removed_out_r;

  // a taken request always leads to a busy period
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request taken but block not busy");

  // the result strobe is a single cycle
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // a result only follows a busy period
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without a preceding request");

  // only ticks report removed sessions
  a_removed_tick_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_TICK_DONE) |-> (out_removed_count == 5'd0))
    else $error("removed count on a datagram result");

endmodule
